// ===== hw/rtl/tppb_pkg.sv =====
// Shared constants, tables and helpers of the two-phase property blend.
package tppb_pkg;

    // register indexes of the configuration port
    localparam logic [2:0] REG_BAND_HALF_WIDTH   = 3'd0;
    localparam logic [2:0] REG_PROPERTY_MODE     = 3'd1;
    localparam logic [2:0] REG_CONST_DENSITY_ONE = 3'd2;
    localparam logic [2:0] REG_CONST_DENSITY_TWO = 3'd3;
    localparam logic [2:0] REG_CONST_VISC_ONE    = 3'd4;
    localparam logic [2:0] REG_CONST_VISC_TWO    = 3'd5;

    // property modes
    localparam logic [1:0] MODE_CONST = 2'd0;
    localparam logic [1:0] MODE_WATER = 2'd1;
    localparam logic [1:0] MODE_AIR   = 2'd2;

    // reset values of the registers
    localparam logic [30:0] RST_BAND_HALF_WIDTH   = 31'd104858;
    localparam logic [1:0]  RST_PROPERTY_MODE     = MODE_CONST;
    localparam logic [26:0] RST_CONST_DENSITY_ONE = 27'd65418035;
    localparam logic [26:0] RST_CONST_DENSITY_TWO = 27'd78971;
    localparam logic [31:0] RST_CONST_VISC_ONE    = 32'd1103910;
    localparam logic [31:0] RST_CONST_VISC_TWO    = 32'd16602626;

    // pipeline latencies in cycles
    localparam int FRAC_LAT  = 43;
    localparam int LUT_LAT   = 30;
    localparam int BLEND_LAT = 2;

    localparam int TABLE_DEPTH_DEF = 20;

    // property tables
    localparam int TAB_WATER_RHO = 0;
    localparam int TAB_AIR_RHO   = 1;
    localparam int TAB_WATER_NU  = 2;
    localparam int TAB_AIR_NU    = 3;
    localparam int TAB_MAX       = 18;
    localparam int TAB_IDX_W     = 5;

    localparam int TAB_CNT [4] = '{15, 18, 12, 18};

    localparam logic signed [15:0] TAB_T [4][TAB_MAX] = '{
        '{-16'sd1920, -16'sd1280, -16'sd640, 16'sd0, 16'sd256, 16'sd640, 16'sd960,
          16'sd1280, 16'sd1408, 16'sd1600, 16'sd1920, 16'sd2560, 16'sd3840,
          16'sd5120, 16'sd6400, 16'sd6400, 16'sd6400, 16'sd6400},
        '{-16'sd9600, -16'sd6400, -16'sd3200, 16'sd0, 16'sd1280, 16'sd2560, 16'sd3840,
          16'sd5120, 16'sd6400, 16'sd7680, 16'sd8960, 16'sd10240, 16'sd11520,
          16'sd12800, 16'sd16000, 16'sd19200, 16'sd22400, 16'sd25600},
        '{16'sd0, 16'sd320, 16'sd640, 16'sd1280, 16'sd1920, 16'sd2560, 16'sd3200,
          16'sd3840, 16'sd4480, 16'sd5120, 16'sd5760, 16'sd6400, 16'sd6400,
          16'sd6400, 16'sd6400, 16'sd6400, 16'sd6400, 16'sd6400},
        '{-16'sd9600, -16'sd6400, -16'sd3200, 16'sd0, 16'sd1280, 16'sd2560, 16'sd3840,
          16'sd5120, 16'sd6400, 16'sd7680, 16'sd8960, 16'sd10240, 16'sd11520,
          16'sd12800, 16'sd16000, 16'sd19200, 16'sd22400, 16'sd25600}
    };

    localparam logic [26:0] TAB_V [4][TAB_MAX] = '{
        '{27'd64477856, 27'd65113096, 27'd65412596, 27'd65525481, 27'd65534165,
          27'd65516510, 27'd65477188, 27'd65418501, 27'd65390084, 27'd65342531,
          27'd65250932, 27'd65024819, 27'd64434995, 27'd63687885, 27'd62809702,
          27'd62809702, 27'd62809702, 27'd62809702},
        '{27'd183042, 27'd129761, 27'd100532, 27'd84738, 27'd78971, 27'd73859,
          27'd69927, 27'd65536, 27'd61997, 27'd58851, 27'd55968, 27'd53412,
          27'd51053, 27'd48890, 27'd44237, 27'd40370, 27'd37093, 27'd34341},
        '{27'd1964827, 27'd1670158, 27'd1437062, 27'd1101711, 27'd877410,
          27'd717981, 27'd601433, 27'd513472, 27'd444203, 27'd390327, 27'd346346,
          27'd310062, 27'd310062, 27'd310062, 27'd310062, 27'd310062, 27'd310062,
          27'd310062},
        '{27'd3386496, 27'd6542094, 27'd10500336, 27'd14623505, 27'd16613621,
          27'd18658712, 27'd20780770, 27'd23023773, 27'd25354738, 27'd27740678,
          27'd30291545, 27'd32820422, 27'd35503230, 27'd38076088, 27'd45266994,
          27'd52611631, 27'd60528115, 27'd68752462}
    };

    // sin(pi s)/pi as an odd polynomial in s, Q30 coefficients
    localparam logic signed [33:0] SINC_COEF [7] = '{
        34'sd1073741824, -34'sd1766234505, 34'sd871601792, -34'sd204818212,
        34'sd28076038, -34'sd2519085, 34'sd159374
    };

    localparam logic signed [35:0] Q30_ONE = 36'sd1073741824;

    // sideband of the fraction divider
    typedef struct packed {
        logic        force_h;
        logic [16:0] forced_h;
        logic        neg;
    } frac_tag_t;

    // sideband of the interpolation divider
    typedef struct packed {
        logic        clamp;
        logic        neg;
        logic [26:0] base;
    } lut_tag_t;

    // Q30 product rounded half up
    function automatic logic signed [33:0] rnd_q30(input logic signed [65:0] p);
        logic signed [65:0] t;
        t = p + 66'sd536870912;
        return t[63:30];
    endfunction

endpackage

// ===== hw/rtl/tppb_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with a sideband.
module tppb_div import tppb_pkg::*; #(
    parameter int DW = 31,
    parameter int QW = 31,
    parameter int TW = 8
) (
    input  logic               aclk,
    input  logic               ce,
    input  logic [DW+QW-1:0]   num,
    input  logic [DW-1:0]      den,
    input  logic [TW-1:0]      tag_in,
    output logic [QW-1:0]      quo,
    output logic [DW-1:0]      rem,
    output logic [TW-1:0]      tag_out
);

    localparam int NW = DW + QW;

    logic [DW-1:0] rem_reg [QW];
    logic [QW-1:0] low_reg [QW];
    logic [QW-1:0] quo_reg [QW];
    logic [DW-1:0] den_reg [QW];
    logic [TW-1:0] tag_reg [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [DW-1:0] rem_in;
        logic [QW-1:0] low_in;
        logic [QW-1:0] quo_in;
        logic [DW-1:0] den_in;
        logic [TW-1:0] tg_in;
        logic [DW:0]   trial;
        logic [DW:0]   diff;

        if (k == 0) begin : g_first
            assign rem_in = num[NW-1:QW];
            assign low_in = num[QW-1:0];
            assign quo_in = '0;
            assign den_in = den;
            assign tg_in  = tag_in;
        end else begin : g_rest
            assign rem_in = rem_reg[k-1];
            assign low_in = low_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign den_in = den_reg[k-1];
            assign tg_in  = tag_reg[k-1];
        end

        assign trial = {rem_in, low_in[QW-1]};
        assign diff  = trial - {1'b0, den_in};

        always_ff @(posedge aclk) begin
            if (ce) begin
                if (trial >= {1'b0, den_in}) begin
                    rem_reg[k] <= diff[DW-1:0];
                    quo_reg[k] <= {quo_in[QW-2:0], 1'b1};
                end else begin
                    rem_reg[k] <= trial[DW-1:0];
                    quo_reg[k] <= {quo_in[QW-2:0], 1'b0};
                end
                low_reg[k] <= {low_in[QW-2:0], 1'b0};
                den_reg[k] <= den_in;
                tag_reg[k] <= tg_in;
            end
        end
    end

    assign quo     = quo_reg[QW-1];
    assign rem     = rem_reg[QW-1];
    assign tag_out = tag_reg[QW-1];

endmodule

// ===== hw/rtl/tppb_frac.sv =====
// Smoothed Heaviside fraction: band divide, sine polynomial, clamp.
module tppb_frac import tppb_pkg::*; (
    input  logic               aclk,
    input  logic               ce,
    input  logic signed [31:0] level_set,
    input  logic [30:0]        eps,
    output logic [16:0]        phase_fraction
);

    logic [31:0] f1_mag_reg;
    logic        f1_neg_reg;
    logic        f1_zero_reg;
    logic [30:0] f1_eps_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            f1_mag_reg  <= level_set[31] ? (~$unsigned(level_set) + 32'd1)
                                         : $unsigned(level_set);
            f1_neg_reg  <= level_set[31];
            f1_zero_reg <= (level_set == 32'sd0);
            f1_eps_reg  <= eps;
        end
    end

    logic [61:0] f2_num_reg;
    logic [30:0] f2_eps_reg;
    frac_tag_t   f2_tag_reg;
    frac_tag_t   f2_tag;

    always_comb begin
        f2_tag.neg      = f1_neg_reg;
        f2_tag.force_h  = 1'b0;
        f2_tag.forced_h = '0;
        if (f1_eps_reg == '0) begin
            f2_tag.force_h  = 1'b1;
            f2_tag.forced_h = f1_neg_reg ? 17'd0 : (f1_zero_reg ? 17'd32768 : 17'd65536);
        end else if (f1_mag_reg > {1'b0, f1_eps_reg}) begin
            f2_tag.force_h  = 1'b1;
            f2_tag.forced_h = f1_neg_reg ? 17'd0 : 17'd65536;
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            f2_num_reg <= {f1_mag_reg, 30'd0} + {31'd0, f1_eps_reg[30:1]};
            f2_eps_reg <= f1_eps_reg;
            f2_tag_reg <= f2_tag;
        end
    end

    logic [30:0] r_q;
    logic [30:0] r_rem;
    logic [$bits(frac_tag_t)-1:0] div_tag;

    tppb_div #(.DW(31), .QW(31), .TW($bits(frac_tag_t))) u_div (
        .aclk    (aclk),
        .ce      (ce),
        .num     (f2_num_reg),
        .den     (f2_eps_reg),
        .tag_in  (f2_tag_reg),
        .quo     (r_q),
        .rem     (r_rem),
        .tag_out (div_tag)
    );

    // fold r into s = min(r, 1 - r)
    logic signed [31:0] r_s;
    logic signed [31:0] sa_s_reg;
    logic [30:0]        sa_r_reg;
    frac_tag_t          sa_tag_reg;

    assign r_s = $signed({1'b0, r_q});

    always_ff @(posedge aclk) begin
        if (ce) begin
            sa_s_reg   <= (r_s <= 32'sd536870912) ? r_s : (32'sd1073741824 - r_s);
            sa_r_reg   <= r_q;
            sa_tag_reg <= div_tag;
        end
    end

    logic signed [63:0] p0_reg;
    logic signed [31:0] p0_s_reg;
    logic [30:0]        p0_r_reg;
    frac_tag_t          p0_tag_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            p0_reg     <= sa_s_reg * sa_s_reg;
            p0_s_reg   <= sa_s_reg;
            p0_r_reg   <= sa_r_reg;
            p0_tag_reg <= sa_tag_reg;
        end
    end

    // Horner steps, one multiply per stage
    logic signed [65:0] prod_reg [7];
    logic signed [31:0] s_reg    [7];
    logic signed [31:0] s2_reg   [7];
    logic [30:0]        r_reg    [7];
    frac_tag_t          tag_reg  [7];

    for (genvar k = 0; k < 7; k++) begin : g_horner
        logic signed [31:0] s_in;
        logic signed [31:0] s2_in;
        logic [30:0]        r_in;
        frac_tag_t          tg_in;
        logic signed [33:0] acc;
        logic signed [33:0] s2_full;
        logic signed [31:0] mult;

        if (k == 0) begin : g_first
            always_comb begin
                s2_full = rnd_q30(66'(p0_reg));
                s2_in   = s2_full[31:0];
                s_in    = p0_s_reg;
                r_in    = p0_r_reg;
                tg_in   = p0_tag_reg;
                acc     = SINC_COEF[6];
            end
        end else begin : g_rest
            always_comb begin
                s2_full = '0;
                s2_in   = s2_reg[k-1];
                s_in    = s_reg[k-1];
                r_in    = r_reg[k-1];
                tg_in   = tag_reg[k-1];
                acc     = SINC_COEF[6-k] + rnd_q30(prod_reg[k-1]);
            end
        end

        assign mult = (k == 6) ? s_in : s2_in;

        always_ff @(posedge aclk) begin
            if (ce) begin
                prod_reg[k] <= acc * mult;
                s_reg[k]    <= s_in;
                s2_reg[k]   <= s2_in;
                r_reg[k]    <= r_in;
                tag_reg[k]  <= tg_in;
            end
        end
    end

    logic signed [33:0] g_raw;
    logic signed [35:0] g_pos;
    logic signed [35:0] t_sum;
    logic signed [35:0] h_sum;
    logic [31:0]        h_clamped;
    logic [16:0]        h_val;
    logic [16:0]        h_reg;
    frac_tag_t          hf_tag;

    always_comb begin
        hf_tag = tag_reg[6];
        g_raw  = rnd_q30(prod_reg[6]);
        g_pos  = g_raw[33] ? 36'sd0 : 36'(g_raw);
        t_sum  = $signed({5'd0, r_reg[6]}) + g_pos;
        h_sum  = hf_tag.neg ? (Q30_ONE - t_sum) : (Q30_ONE + t_sum);
        // clamp to [0, 2^31]
        if (h_sum < 36'sd0) begin
            h_clamped = '0;
        end else if (h_sum > 36'sd2147483648) begin
            h_clamped = 32'h8000_0000;
        end else begin
            h_clamped = h_sum[31:0];
        end
        h_val = 17'((33'(h_clamped) + 33'd16384) >> 15);
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            h_reg <= hf_tag.force_h ? hf_tag.forced_h : h_val;
        end
    end

    assign phase_fraction = h_reg;

endmodule

// ===== hw/rtl/tppb_lut.sv =====
// Piecewise-linear property table with clamping and rounded interpolation.
module tppb_lut import tppb_pkg::*; #(
    parameter int TAB_ID = TAB_WATER_RHO,
    parameter int DEPTH  = TABLE_DEPTH_DEF
) (
    input  logic               aclk,
    input  logic               ce,
    input  logic signed [15:0] temperature,
    output logic [26:0]        value
);

    localparam int NP = (TAB_CNT[TAB_ID] < DEPTH) ? TAB_CNT[TAB_ID] : DEPTH;
    localparam int CW = $clog2(NP + 1);

    // count the points that lie below the temperature
    logic [CW-1:0]      cnt_c;
    logic [CW-1:0]      l1_cnt_reg;
    logic signed [15:0] l1_x_reg;

    always_comb begin
        cnt_c = '0;
        for (int i = 0; i < NP; i++) begin
            cnt_c = cnt_c + CW'(temperature > TAB_T[TAB_ID][i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            l1_cnt_reg <= cnt_c;
            l1_x_reg   <= temperature;
        end
    end

    logic                 lo_c;
    logic                 hi_c;
    logic [TAB_IDX_W-1:0] k_c;
    logic signed [15:0]   t0_c;
    logic signed [15:0]   t1_c;
    logic [26:0]          v0_c;
    logic [26:0]          v1_c;

    always_comb begin
        lo_c = (l1_cnt_reg == '0);
        hi_c = (l1_cnt_reg == CW'(NP));
        if (lo_c) begin
            k_c = '0;
        end else if (hi_c) begin
            k_c = TAB_IDX_W'(NP - 2);
        end else begin
            k_c = TAB_IDX_W'(l1_cnt_reg - CW'(1));
        end
        t0_c = TAB_T[TAB_ID][k_c];
        t1_c = TAB_T[TAB_ID][k_c + TAB_IDX_W'(1)];
        v0_c = TAB_V[TAB_ID][k_c];
        v1_c = TAB_V[TAB_ID][k_c + TAB_IDX_W'(1)];
    end

    logic signed [16:0] l2_dx_reg;
    logic signed [16:0] l2_den_reg;
    logic signed [27:0] l2_dv_reg;
    logic               l2_clamp_reg;
    logic [26:0]        l2_base_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            l2_dx_reg    <= 17'(l1_x_reg) - 17'(t0_c);
            l2_den_reg   <= 17'(t1_c) - 17'(t0_c);
            l2_dv_reg    <= $signed({1'b0, v1_c}) - $signed({1'b0, v0_c});
            l2_clamp_reg <= lo_c | hi_c;
            l2_base_reg  <= lo_c ? TAB_V[TAB_ID][0] : (hi_c ? TAB_V[TAB_ID][NP-1] : v0_c);
        end
    end

    logic signed [44:0] l3_num_reg;
    logic signed [16:0] l3_den_reg;
    logic               l3_clamp_reg;
    logic [26:0]        l3_base_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            l3_num_reg   <= l2_dv_reg * l2_dx_reg;
            l3_den_reg   <= l2_den_reg;
            l3_clamp_reg <= l2_clamp_reg;
            l3_base_reg  <= l2_base_reg;
        end
    end

    // floor((2 num + den) / (2 den)) on magnitudes
    logic signed [45:0] nn_c;
    logic [45:0]        nmag_c;
    lut_tag_t           l4_tag;
    logic [42:0]        l4_mag_reg;
    logic [17:0]        l4_d_reg;
    lut_tag_t           l4_tag_reg;

    always_comb begin
        nn_c         = {l3_num_reg, 1'b0} + 46'(l3_den_reg);
        nmag_c       = nn_c[45] ? $unsigned(-nn_c) : $unsigned(nn_c);
        l4_tag.clamp = l3_clamp_reg;
        l4_tag.neg   = nn_c[45];
        l4_tag.base  = l3_base_reg;
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            l4_mag_reg <= nmag_c[42:0];
            l4_d_reg   <= {l3_den_reg[16:0], 1'b0};
            l4_tag_reg <= l4_tag;
        end
    end

    logic [24:0] q_raw;
    logic [17:0] q_rem;
    lut_tag_t    q_tag;

    tppb_div #(.DW(18), .QW(25), .TW($bits(lut_tag_t))) u_div (
        .aclk    (aclk),
        .ce      (ce),
        .num     (l4_mag_reg),
        .den     (l4_d_reg),
        .tag_in  (l4_tag_reg),
        .quo     (q_raw),
        .rem     (q_rem),
        .tag_out (q_tag)
    );

    logic [25:0] q_adj;
    logic [27:0] v_sum;
    logic [26:0] value_reg;

    always_comb begin
        q_adj = {1'b0, q_raw} + 26'((q_tag.neg && q_rem != '0) ? 1 : 0);
        if (q_tag.neg) begin
            v_sum = {1'b0, q_tag.base} - {2'b0, q_adj};
        end else begin
            v_sum = {1'b0, q_tag.base} + {2'b0, q_adj};
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            value_reg <= q_tag.clamp ? q_tag.base : v_sum[26:0];
        end
    end

    assign value = value_reg;

endmodule

// ===== hw/rtl/two_phase_property_blend_unit.sv =====
// Top level of the two-phase property blend: registers, timing alignment, blend.
//
// One grid cell enters per item on the s_ channel: a level-set distance and a
// temperature. One result leaves per item on the m_ channel: blended density,
// blended kinematic viscosity and the smoothed Heaviside fraction.
// Registers are written through cfg_we / cfg_addr / cfg_wdata; the user must
// write them only while the block is idle, as the block does not enforce it;
// indexes past the last register are ignored. The datapath has 2 stages of
// band setup, a 31-stage divider for the band ratio, 10 stages of sine
// polynomial, rounding and clamp, then 2 stages of blend multiply and sum. The
// property tables run a 30-stage path in parallel and are delayed to meet the
// fraction. Throughput is one item per clock cycle while the output does not
// stall. The whole pipeline advances together: when m_tvalid is high and
// m_tready is low, it holds and s_tready drops; nothing is lost or repeated.
// Reset clears all valid bits and loads the register defaults.
module two_phase_property_blend_unit import tppb_pkg::*; #(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // level_set[31:0], temperature[47:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // density[26:0], viscosity[58:27], phase_fraction[75:59]
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata
);

    localparam int PIPE_LAT = FRAC_LAT + BLEND_LAT;
    localparam int LUT_DLY  = FRAC_LAT - LUT_LAT;

    logic [30:0] band_half_width_reg;
    logic [1:0]  property_mode_reg;
    logic [26:0] const_density_one_reg;
    logic [26:0] const_density_two_reg;
    logic [31:0] const_visc_one_reg;
    logic [31:0] const_visc_two_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            band_half_width_reg   <= RST_BAND_HALF_WIDTH;
            property_mode_reg     <= RST_PROPERTY_MODE;
            const_density_one_reg <= RST_CONST_DENSITY_ONE;
            const_density_two_reg <= RST_CONST_DENSITY_TWO;
            const_visc_one_reg    <= RST_CONST_VISC_ONE;
            const_visc_two_reg    <= RST_CONST_VISC_TWO;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_BAND_HALF_WIDTH:   band_half_width_reg   <= cfg_wdata[30:0];
                REG_PROPERTY_MODE:     property_mode_reg     <= cfg_wdata[1:0];
                REG_CONST_DENSITY_ONE: const_density_one_reg <= cfg_wdata[26:0];
                REG_CONST_DENSITY_TWO: const_density_two_reg <= cfg_wdata[26:0];
                REG_CONST_VISC_ONE:    const_visc_one_reg    <= cfg_wdata;
                REG_CONST_VISC_TWO:    const_visc_two_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // pipeline advance
    logic                ce;
    logic [PIPE_LAT-1:0] vld_reg;
    logic [PIPE_LAT-1:0] vld_next;

    assign ce       = !vld_reg[PIPE_LAT-1] || m_tready;
    assign s_tready = ce;
    assign m_tvalid = vld_reg[PIPE_LAT-1];
    assign vld_next = {vld_reg[PIPE_LAT-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= vld_next;
        end
    end

    logic signed [31:0] in_level_set;
    logic signed [15:0] in_temperature;
    logic [16:0]        h_frac;

    assign in_level_set   = $signed(s_tdata[31:0]);
    assign in_temperature = $signed(s_tdata[47:32]);

    tppb_frac u_frac (
        .aclk           (aclk),
        .ce             (ce),
        .level_set      (in_level_set),
        .eps            (band_half_width_reg),
        .phase_fraction (h_frac)
    );

    logic [26:0] lut_val [4];

    for (genvar t = 0; t < 4; t++) begin : g_lut
        tppb_lut #(.TAB_ID(t), .DEPTH(TABLE_DEPTH)) u_lut (
            .aclk        (aclk),
            .ce          (ce),
            .temperature (in_temperature),
            .value       (lut_val[t])
        );
    end

    // delay the table values to meet the fraction
    logic [26:0] dly_reg [LUT_DLY][4];

    for (genvar d = 0; d < LUT_DLY; d++) begin : g_dly
        for (genvar t = 0; t < 4; t++) begin : g_tab
            always_ff @(posedge aclk) begin
                if (ce) begin
                    dly_reg[d][t] <= (d == 0) ? lut_val[t] : dly_reg[(d == 0) ? 0 : d-1][t];
                end
            end
        end
    end

    logic [26:0] rho_one;
    logic [26:0] rho_two;
    logic [31:0] nu_one;
    logic [31:0] nu_two;
    logic [16:0] h_inv;

    always_comb begin
        unique case (property_mode_reg)
            MODE_WATER: begin
                rho_one = dly_reg[LUT_DLY-1][TAB_WATER_RHO];
                rho_two = dly_reg[LUT_DLY-1][TAB_AIR_RHO];
                nu_one  = {5'd0, dly_reg[LUT_DLY-1][TAB_WATER_NU]};
                nu_two  = {5'd0, dly_reg[LUT_DLY-1][TAB_AIR_NU]};
            end
            MODE_AIR: begin
                rho_one = dly_reg[LUT_DLY-1][TAB_AIR_RHO];
                rho_two = dly_reg[LUT_DLY-1][TAB_WATER_RHO];
                nu_one  = {5'd0, dly_reg[LUT_DLY-1][TAB_AIR_NU]};
                nu_two  = {5'd0, dly_reg[LUT_DLY-1][TAB_WATER_NU]};
            end
            default: begin
                rho_one = const_density_one_reg;
                rho_two = const_density_two_reg;
                nu_one  = const_visc_one_reg;
                nu_two  = const_visc_two_reg;
            end
        endcase
        h_inv = 17'd65536 - h_frac;
    end

    logic [43:0] b1_rho_a_reg;
    logic [43:0] b1_rho_b_reg;
    logic [48:0] b1_nu_a_reg;
    logic [48:0] b1_nu_b_reg;
    logic [16:0] b1_h_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            b1_rho_a_reg <= rho_one * h_frac;
            b1_rho_b_reg <= rho_two * h_inv;
            b1_nu_a_reg  <= nu_one * h_frac;
            b1_nu_b_reg  <= nu_two * h_inv;
            b1_h_reg     <= h_frac;
        end
    end

    logic [44:0] rho_sum;
    logic [49:0] nu_sum;
    logic [79:0] m_tdata_reg;

    assign rho_sum = 45'(b1_rho_a_reg) + 45'(b1_rho_b_reg) + 45'd32768;
    assign nu_sum  = 50'(b1_nu_a_reg) + 50'(b1_nu_b_reg) + 50'd32768;

    always_ff @(posedge aclk) begin
        if (ce) begin
            m_tdata_reg <= {4'd0, b1_h_reg, nu_sum[47:16], rho_sum[42:16]};
        end
    end

    assign m_tdata = m_tdata_reg;

    // an empty output stage never blocks the input
    assert property (@(posedge aclk) disable iff (!aresetn) !m_tvalid |-> s_tready)
        else $error("input blocked with no result pending");

    // a held pipeline keeps its valid bits
    assert property (@(posedge aclk) disable iff (!aresetn) !s_tready |=> $stable(vld_reg))
        else $error("valid bits moved during a stall");

    // the fraction never exceeds one
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[75:59] <= 17'd65536))
        else $error("phase fraction out of range");

endmodule

// ===== tb/tb_two_phase_property_blend_unit.sv =====
// Self-checking testbench of the two-phase property blend unit.
`timescale 1ns / 1ps

module tb_two_phase_property_blend_unit;
    import tppb_pkg::*;

    localparam logic [2:0] REG_SPARE_A = 3'd6;
    localparam logic [2:0] REG_SPARE_B = 3'd7;
    localparam longint Q30 = 64'sd1073741824;
    localparam int DRAIN_CYCLES = 60;
    localparam int HOLD_CYCLES = 400;

    typedef struct {
        logic [26:0] density;
        logic [31:0] viscosity;
        logic [16:0] phase_fraction;
    } cell_result_t;

    typedef struct {
        logic [31:0]  level_set;
        logic [15:0]  temperature;
        bit           typed;
        cell_result_t res;
    } cell_row_t;

    // phase tables: water rho, air rho, water nu, air nu
    localparam int PT_CNT [4] = '{15, 18, 12, 18};
    localparam int PT_T [4][18] = '{
        '{-1920, -1280, -640, 0, 256, 640, 960, 1280, 1408, 1600, 1920, 2560, 3840,
          5120, 6400, 0, 0, 0},
        '{-9600, -6400, -3200, 0, 1280, 2560, 3840, 5120, 6400, 7680, 8960, 10240,
          11520, 12800, 16000, 19200, 22400, 25600},
        '{0, 320, 640, 1280, 1920, 2560, 3200, 3840, 4480, 5120, 5760, 6400,
          0, 0, 0, 0, 0, 0},
        '{-9600, -6400, -3200, 0, 1280, 2560, 3840, 5120, 6400, 7680, 8960, 10240,
          11520, 12800, 16000, 19200, 22400, 25600}
    };
    localparam longint PT_V [4][18] = '{
        '{64477856, 65113096, 65412596, 65525481, 65534165, 65516510, 65477188,
          65418501, 65390084, 65342531, 65250932, 65024819, 64434995, 63687885,
          62809702, 0, 0, 0},
        '{183042, 129761, 100532, 84738, 78971, 73859, 69927, 65536, 61997, 58851,
          55968, 53412, 51053, 48890, 44237, 40370, 37093, 34341},
        '{1964827, 1670158, 1437062, 1101711, 877410, 717981, 601433, 513472,
          444203, 390327, 346346, 310062, 0, 0, 0, 0, 0, 0},
        '{3386496, 6542094, 10500336, 14623505, 16613621, 18658712, 20780770,
          23023773, 25354738, 27740678, 30291545, 32820422, 35503230, 38076088,
          45266994, 52611631, 60528115, 68752462}
    };
    localparam longint POLY [7] = '{1073741824, -1766234505, 871601792, -204818212,
                                    28076038, -2519085, 159374};

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [31:0] cfg_wdata = '0;

    // shadow registers
    logic [30:0] band_hw;
    logic [1:0]  prop_mode;
    logic [26:0] rho_one, rho_two;
    logic [31:0] nu_one, nu_two;

    cell_result_t pending_cells [$];
    int errors = 0;
    int results_seen = 0;

    two_phase_property_blend_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    initial begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

    function automatic longint fdiv(longint n, longint d);
        longint q;
        q = n / d;
        if ((n % d) != 0 && n < 0) q -= 1;
        return q;
    endfunction

    function automatic longint mul_q30(longint a, longint b);
        return fdiv(a * b + Q30 / 2, Q30);
    endfunction

    function automatic longint table_value(int tab, int x);
        int n;
        longint dv, den;
        n = PT_CNT[tab];
        if (x <= PT_T[tab][0]) return PT_V[tab][0];
        if (x > PT_T[tab][n-1]) return PT_V[tab][n-1];
        for (int k = 0; k + 1 < n; k++) begin
            if (x > PT_T[tab][k] && x <= PT_T[tab][k+1]) begin
                dv = PT_V[tab][k+1] - PT_V[tab][k];
                den = PT_T[tab][k+1] - PT_T[tab][k];
                return PT_V[tab][k] + fdiv(2 * dv * (x - PT_T[tab][k]) + den, 2 * den);
            end
        end
        return PT_V[tab][n-1];
    endfunction

    function automatic longint heaviside(longint phi, longint eps);
        longint mag, r, s, s2, acc, g, sum, h;
        mag = phi < 0 ? -phi : phi;
        if (eps == 0) return phi > 0 ? 65536 : (phi < 0 ? 0 : 32768);
        if (mag > eps) return phi > 0 ? 65536 : 0;
        r = ((mag << 30) + eps / 2) / eps;
        s = (r <= Q30 / 2) ? r : Q30 - r;
        s2 = mul_q30(s, s);
        acc = POLY[6];
        for (int k = 5; k >= 0; k--) acc = POLY[k] + mul_q30(acc, s2);
        g = mul_q30(acc, s);
        if (g < 0) g = 0;
        sum = phi >= 0 ? Q30 + r + g : Q30 - r - g;
        if (sum < 0) sum = 0;
        if (sum > 2 * Q30) sum = 2 * Q30;
        h = (sum + (1 << 14)) >>> 15;
        return h > 65536 ? 65536 : h;
    endfunction

    function automatic cell_result_t blend_cell(logic [31:0] ls, logic [15:0] tc);
        cell_result_t res;
        longint r1, r2, n1, n2, h, rw, ra, nw, na;
        r1 = rho_one; r2 = rho_two; n1 = nu_one; n2 = nu_two;
        if (prop_mode == MODE_WATER || prop_mode == MODE_AIR) begin
            rw = table_value(0, $signed(tc));
            ra = table_value(1, $signed(tc));
            nw = table_value(2, $signed(tc));
            na = table_value(3, $signed(tc));
            if (prop_mode == MODE_WATER) begin
                r1 = rw; r2 = ra; n1 = nw; n2 = na;
            end else begin
                r1 = ra; r2 = rw; n1 = na; n2 = nw;
            end
        end
        h = heaviside(longint'($signed(ls)), longint'(band_hw));
        res.density = 27'((r1 * h + r2 * (65536 - h) + 32768) >> 16);
        res.viscosity = 32'((n1 * h + n2 * (65536 - h) + 32768) >> 16);
        res.phase_fraction = 17'(h);
        return res;
    endfunction

    // drive one write; the caller drops cfg_we after the last one
    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            REG_BAND_HALF_WIDTH:   band_hw = val[30:0];
            REG_PROPERTY_MODE:     prop_mode = val[1:0];
            REG_CONST_DENSITY_ONE: rho_one = val[26:0];
            REG_CONST_DENSITY_TWO: rho_two = val[26:0];
            REG_CONST_VISC_ONE:    nu_one = val;
            REG_CONST_VISC_TWO:    nu_two = val;
            default: ;
        endcase
    endtask

    // offer one item after a random gap, return once it is accepted
    task automatic send_cell(logic [31:0] ls, logic [15:0] tc, bit typed, cell_result_t res);
        int gap;
        gap = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {tc, ls};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        pending_cells.push_back(typed ? res : blend_cell(ls, tc));
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_cells.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    function automatic logic [31:0] pick_level_set();
        longint eps, mag;
        int sel;
        eps = band_hw;
        sel = $urandom_range(0, 9);
        case (sel)
            0: return $urandom;
            1: mag = eps + $urandom_range(0, 2);
            2: mag = $urandom_range(0, 1);
            3: mag = (eps > 2) ? eps - $urandom_range(0, 2) : eps;
            default: mag = $urandom_range(0, 32'(eps));
        endcase
        return $urandom_range(0, 1) ? 32'(mag) : 32'(-mag);
    endfunction

    function automatic logic [15:0] pick_temperature();
        int sel, tab;
        sel = $urandom_range(0, 5);
        tab = $urandom_range(0, 3);
        if (sel == 0) return $urandom;
        if (sel == 1)
            return 16'(PT_T[tab][$urandom_range(0, PT_CNT[tab] - 1)] + $urandom_range(0, 2) - 1);
        return 16'($urandom_range(0, 38000) - 11000);
    endfunction

    // receiver: random stalls plus one long hold-off
    initial begin
        int stall;
        cell_result_t want;
        @(posedge aresetn);
        forever begin
            stall = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : 0;
            if (results_seen == 300) stall = HOLD_CYCLES;
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
            results_seen++;
            if (pending_cells.size() == 0) begin
                $error("result without a pending item: %h", m_tdata);
                errors++;
            end else begin
                want = pending_cells.pop_front();
                if (m_tdata[26:0] !== want.density) begin
                    $error("density expected %0d actual %0d", want.density, m_tdata[26:0]);
                    errors++;
                end
                if (m_tdata[58:27] !== want.viscosity) begin
                    $error("viscosity expected %0d actual %0d", want.viscosity, m_tdata[58:27]);
                    errors++;
                end
                if (m_tdata[75:59] !== want.phase_fraction) begin
                    $error("phase_fraction expected %0d actual %0d",
                           want.phase_fraction, m_tdata[75:59]);
                    errors++;
                end
            end
        end
    end

    initial begin
        cell_row_t rows [$];
        cell_result_t none;
        logic [31:0] pcfg [8][6];
        int eps0;
        none = '{default: '0};
        band_hw = RST_BAND_HALF_WIDTH;
        prop_mode = RST_PROPERTY_MODE;
        rho_one = RST_CONST_DENSITY_ONE;
        rho_two = RST_CONST_DENSITY_TWO;
        nu_one = RST_CONST_VISC_ONE;
        nu_two = RST_CONST_VISC_TWO;
        eps0 = RST_BAND_HALF_WIDTH;

        // fully phase one, fully phase two, the interface itself, and cells at, inside and just past the band edges
        rows.push_back('{32'h7fffffff, 16'h8000, 1, '{65418035, 1103910, 65536}});
        rows.push_back('{32'h80000000, 16'h7fff, 1, '{78971, 16602626, 0}});
        rows.push_back('{32'd0, 16'd0, 1, '{32748503, 8853268, 32768}});
        rows.push_back('{32'(eps0), 16'd100, 0, none});
        rows.push_back('{32'(-eps0), 16'd100, 0, none});
        rows.push_back('{32'(eps0 + 1), 16'd0, 1, '{65418035, 1103910, 65536}});
        rows.push_back('{32'(-eps0 - 1), 16'd0, 1, '{78971, 16602626, 0}});
        rows.push_back('{32'(eps0 - 1), 16'd0, 0, none});
        rows.push_back('{32'(eps0 / 2), 16'd0, 0, none});
        rows.push_back('{32'(-eps0 / 2), 16'd0, 0, none});
        rows.push_back('{32'd1, 16'h8000, 0, none});
        rows.push_back('{32'hffffffff, 16'h7fff, 0, none});
        rows.push_back('{32'(eps0 / 4), 16'hffff, 0, none});
        rows.push_back('{32'(-eps0 * 3 / 4), 16'h0001, 0, none});

        // band, mode, density one, density two, viscosity one, viscosity two
        pcfg[0] = '{104858, MODE_WATER, 65418035, 78971, 1103910, 16602626};
        pcfg[1] = '{104858, MODE_AIR, 1, 2, 3, 4};
        pcfg[2] = '{1, 3, 134217727, 0, 32'hffffffff, 0};
        pcfg[3] = '{31'h7fffffff, MODE_CONST, 0, 134217727, 0, 32'hffffffff};
        pcfg[4] = '{0, MODE_WATER, 5, 6, 7, 8};
        pcfg[5] = '{$urandom, $urandom_range(0, 3), $urandom, $urandom, $urandom, $urandom};
        pcfg[6] = '{1048576, MODE_AIR, 0, 0, 0, 0};
        pcfg[7] = '{$urandom_range(1, 4000000), MODE_CONST, $urandom, $urandom,
                    $urandom, $urandom};

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (rows[i]) send_cell(rows[i].level_set, rows[i].temperature,
                                    rows[i].typed, rows[i].res);
        drain();

        for (int p = 0; p < 8; p++) begin
            write_reg(REG_BAND_HALF_WIDTH, pcfg[p][0]);
            write_reg(REG_PROPERTY_MODE, pcfg[p][1]);
            write_reg(REG_CONST_DENSITY_ONE, pcfg[p][2]);
            write_reg(REG_CONST_DENSITY_TWO, pcfg[p][3]);
            write_reg(REG_CONST_VISC_ONE, pcfg[p][4]);
            write_reg(REG_CONST_VISC_TWO, pcfg[p][5]);
            // spare indexes must not disturb anything
            write_reg(REG_SPARE_A, $urandom);
            write_reg(REG_SPARE_B, $urandom);
            cfg_we <= 1'b0;
            repeat (120) send_cell(pick_level_set(), pick_temperature(), 0, none);
            drain();
        end

        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/tppb_pkg.sv
hw/rtl/tppb_div.sv
hw/rtl/tppb_frac.sv
hw/rtl/tppb_lut.sv
hw/rtl/two_phase_property_blend_unit.sv
tb/tb_two_phase_property_blend_unit.sv
